@@ rtl/tmwp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmwp_pkg: shared types and codes for the tensor message wire parser
// beat structs, field, kind and error codes, key field numbers
// ----------------------------------------------------------------------------
package tmwp_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  field_code;
    logic [1:0]  item_kind;
    logic [63:0] item_value;
    logic        payload_last;
    logic        message_done;
    logic [2:0]  error_code;
  } out_beat_t;

  // field codes
  localparam logic [2:0] FC_DIMS        = 3'd0;
  localparam logic [2:0] FC_DTYPE       = 3'd1;
  localparam logic [2:0] FC_NAME        = 3'd2;
  localparam logic [2:0] FC_RAW         = 3'd3;
  localparam logic [2:0] FC_DOC         = 3'd4;
  localparam logic [2:0] FC_ENTRY_KEY   = 3'd5;
  localparam logic [2:0] FC_ENTRY_VALUE = 3'd6;
  localparam logic [2:0] FC_ENTRY       = 3'd7;

  // item kinds
  localparam logic [1:0] KIND_VARINT  = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_VARINT_LONG   = 3'd1;
  localparam logic [2:0] ERR_WIRE_TYPE     = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN_FIELD = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED     = 3'd4;

  // wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  // field numbers
  localparam logic [60:0] FNUM_DIMS  = 61'd1;
  localparam logic [60:0] FNUM_DTYPE = 61'd2;
  localparam logic [60:0] FNUM_NAME  = 61'd8;
  localparam logic [60:0] FNUM_RAW   = 61'd9;
  localparam logic [60:0] FNUM_DOC   = 61'd12;
  localparam logic [60:0] FNUM_ENTRY = 61'd16;
  localparam logic [60:0] FNUM_KEY   = 61'd1;
  localparam logic [60:0] FNUM_VALUE = 61'd2;

endpackage

@@ rtl/tmwp_decode.sv @@
// ----------------------------------------------------------------------------
// tmwp_decode: parse state and single-byte decode step
// holds varint, payload and entry state; works out at most one result per beat
// ----------------------------------------------------------------------------
module tmwp_decode #(
  parameter int unsigned MaxBytes = tmwp_pkg::MAX_VARINT_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  tmwp_pkg::in_beat_t  beat,
  output logic                res_valid,
  output tmwp_pkg::out_beat_t res
);

  typedef enum logic [4:0] {
    PH_KEY     = 5'b00001,
    PH_VALUE   = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [2:0]  cur_field, cur_field_next;
  logic [63:0] pay_rem, pay_rem_next;
  logic [63:0] ent_rem, ent_rem_next;
  logic        in_entry, in_entry_next;

  logic [6:0]  shamt;
  logic [63:0] shifted;
  logic [63:0] varint_val;
  logic [3:0]  cnt_inc;
  logic [60:0] fnum;
  logic [2:0]  wt;
  logic [2:0]  err;
  logic        have;
  logic [1:0]  kind;
  logic [63:0] value;
  logic        last;
  logic        clear_msg;

  assign shamt      = ({3'b000, cnt} << 3) - {3'b000, cnt};
  assign shifted    = {57'b0, beat.in_byte[6:0]} << shamt;
  assign varint_val = acc | shifted;
  assign cnt_inc    = cnt + 4'd1;
  assign fnum       = varint_val[63:3];
  assign wt         = varint_val[2:0];

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    cur_field_next = cur_field;
    pay_rem_next   = pay_rem;
    ent_rem_next   = ent_rem;
    in_entry_next  = in_entry;
    err            = tmwp_pkg::ERR_NONE;
    have           = 1'b0;
    kind           = tmwp_pkg::KIND_NONE;
    value          = '0;
    last           = 1'b0;
    clear_msg      = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    res.item_kind  = tmwp_pkg::KIND_NONE;

    if (step) begin
      if (phase == PH_DRAIN) begin
        if (beat.end_of_message) begin
          res_valid        = 1'b1;
          res.message_done = 1'b1;
          clear_msg        = 1'b1;
        end
      end else begin
        if (in_entry && ent_rem != 64'd0) begin
          ent_rem_next = ent_rem - 64'd1;
        end

        if (phase == PH_PAYLOAD) begin
          if (pay_rem != 64'd0) begin
            pay_rem_next = pay_rem - 64'd1;
          end
          have  = 1'b1;
          kind  = tmwp_pkg::KIND_PAYLOAD;
          value = {56'b0, beat.in_byte};
          if (pay_rem_next == 64'd0) begin
            last       = 1'b1;
            phase_next = PH_KEY;
          end
        end else if (beat.in_byte[7]) begin
          acc_next = varint_val;
          cnt_next = cnt_inc;
          if (cnt_inc >= 4'(MaxBytes)) begin
            err = tmwp_pkg::ERR_VARINT_LONG;
          end
        end else begin
          acc_next = '0;
          cnt_next = '0;
          case (phase)
            PH_KEY: begin
              if (in_entry) begin
                if (wt != tmwp_pkg::WT_LEN) begin
                  err = tmwp_pkg::ERR_WIRE_TYPE;
                end else if (fnum == tmwp_pkg::FNUM_KEY) begin
                  cur_field_next = tmwp_pkg::FC_ENTRY_KEY;
                  phase_next     = PH_LENGTH;
                end else if (fnum == tmwp_pkg::FNUM_VALUE) begin
                  cur_field_next = tmwp_pkg::FC_ENTRY_VALUE;
                  phase_next     = PH_LENGTH;
                end else begin
                  err = tmwp_pkg::ERR_UNKNOWN_FIELD;
                end
              end else if (fnum == tmwp_pkg::FNUM_DIMS || fnum == tmwp_pkg::FNUM_DTYPE) begin
                if (wt != tmwp_pkg::WT_VARINT) begin
                  err = tmwp_pkg::ERR_WIRE_TYPE;
                end else begin
                  cur_field_next = (fnum == tmwp_pkg::FNUM_DIMS) ? tmwp_pkg::FC_DIMS
                                                                 : tmwp_pkg::FC_DTYPE;
                  phase_next     = PH_VALUE;
                end
              end else if (fnum == tmwp_pkg::FNUM_NAME || fnum == tmwp_pkg::FNUM_RAW ||
                           fnum == tmwp_pkg::FNUM_DOC || fnum == tmwp_pkg::FNUM_ENTRY) begin
                if (fnum == tmwp_pkg::FNUM_NAME) begin
                  cur_field_next = tmwp_pkg::FC_NAME;
                end else if (fnum == tmwp_pkg::FNUM_RAW) begin
                  cur_field_next = tmwp_pkg::FC_RAW;
                end else if (fnum == tmwp_pkg::FNUM_DOC) begin
                  cur_field_next = tmwp_pkg::FC_DOC;
                end else begin
                  cur_field_next = tmwp_pkg::FC_ENTRY;
                end
                if (wt != tmwp_pkg::WT_LEN) begin
                  err = tmwp_pkg::ERR_WIRE_TYPE;
                end else begin
                  phase_next = PH_LENGTH;
                end
              end else begin
                err = tmwp_pkg::ERR_UNKNOWN_FIELD;
              end
            end
            PH_VALUE: begin
              have       = 1'b1;
              kind       = tmwp_pkg::KIND_VARINT;
              value      = varint_val;
              phase_next = PH_KEY;
            end
            PH_LENGTH: begin
              if (in_entry && varint_val > ent_rem_next) begin
                err = tmwp_pkg::ERR_TRUNCATED;
              end else begin
                have  = 1'b1;
                kind  = tmwp_pkg::KIND_LENGTH;
                value = varint_val;
                if (cur_field == tmwp_pkg::FC_ENTRY) begin
                  if (varint_val != 64'd0) begin
                    in_entry_next = 1'b1;
                    ent_rem_next  = varint_val;
                  end
                  phase_next = PH_KEY;
                end else begin
                  pay_rem_next = varint_val;
                  phase_next   = (varint_val != 64'd0) ? PH_PAYLOAD : PH_KEY;
                end
              end
            end
            default: begin
            end
          endcase
        end

        // entry boundary
        if (err == tmwp_pkg::ERR_NONE && in_entry_next && ent_rem_next == 64'd0) begin
          if (phase_next == PH_KEY && cnt_next == 4'd0) begin
            in_entry_next = 1'b0;
          end else begin
            err = tmwp_pkg::ERR_TRUNCATED;
          end
        end

        if (err == tmwp_pkg::ERR_NONE && beat.end_of_message &&
            (phase_next != PH_KEY || cnt_next != 4'd0 || in_entry_next)) begin
          err = tmwp_pkg::ERR_TRUNCATED;
        end

        if (err != tmwp_pkg::ERR_NONE) begin
          res_valid        = 1'b1;
          res.message_done = beat.end_of_message;
          res.error_code   = err;
          if (beat.end_of_message) begin
            clear_msg = 1'b1;
          end else begin
            phase_next = PH_DRAIN;
            acc_next   = '0;
            cnt_next   = '0;
          end
        end else if (beat.end_of_message || have) begin
          res_valid        = 1'b1;
          res.message_done = beat.end_of_message;
          if (have) begin
            res.field_code   = cur_field;
            res.item_kind    = kind;
            res.item_value   = value;
            res.payload_last = last;
          end
          clear_msg = beat.end_of_message;
        end
      end

      if (clear_msg) begin
        phase_next     = PH_KEY;
        acc_next       = '0;
        cnt_next       = '0;
        cur_field_next = '0;
        pay_rem_next   = '0;
        ent_rem_next   = '0;
        in_entry_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_KEY;
      acc       <= '0;
      cnt       <= '0;
      cur_field <= '0;
      pay_rem   <= '0;
      ent_rem   <= '0;
      in_entry  <= 1'b0;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      cur_field <= cur_field_next;
      pay_rem   <= pay_rem_next;
      ent_rem   <= ent_rem_next;
      in_entry  <= in_entry_next;
    end
  end

endmodule

@@ rtl/tensor_message_wire_parser_core.sv @@
// ----------------------------------------------------------------------------
// tensor_message_wire_parser_core: byte-wide tensor message wire decoder
// path: a byte waits in the input register, its result in the result register
// throughput: one byte per cycle, set by the parse step, if no result stalls
// reset: synchronous rst clears parse state and both stage valid bits at once
// ----------------------------------------------------------------------------
module tensor_message_wire_parser_core #(
  parameter int unsigned MaxBytes = tmwp_pkg::MAX_VARINT_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  tmwp_pkg::in_beat_t  byte_beat,
  output logic                result_valid,
  input  logic                result_stall,
  output tmwp_pkg::out_beat_t result_beat
);

  logic                a_valid;
  tmwp_pkg::in_beat_t  a_beat;
  logic                advance;
  logic                take;
  logic                dec_valid;
  tmwp_pkg::out_beat_t dec_res;

  assign advance    = a_valid && (!result_valid || !result_stall);
  assign byte_stall = a_valid && !advance;
  assign take       = byte_valid && !byte_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_beat <= byte_beat;
    end
  end

  tmwp_decode #(
    .MaxBytes (MaxBytes)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .beat      (a_beat),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= dec_valid;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_valid) begin
      result_beat <= dec_res;
    end
  end

  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_beat.item_kind != tmwp_pkg::KIND_NONE ||
                      result_beat.error_code != tmwp_pkg::ERR_NONE ||
                      result_beat.message_done))
    else $error("empty result beat");

  a_error_bare: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_beat.error_code != tmwp_pkg::ERR_NONE) |->
      (result_beat.item_kind == tmwp_pkg::KIND_NONE && result_beat.item_value == 64'd0))
    else $error("error beat carries an item");

  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_beat.payload_last) |->
      result_beat.item_kind == tmwp_pkg::KIND_PAYLOAD)
    else $error("payload_last outside payload");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (a_valid && result_valid && result_stall))
    else $error("input stalled without a held result");

endmodule

@@ tb/tensor_message_wire_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// tensor_message_wire_parser_core_tb: self-checking bench for the wire parser
// feeds whole messages one byte per beat (directed corner cases, then random
// well-formed, damaged and noise messages), predicts every result beat from
// its own copy of the parse state and checks them in order, field by field
// ----------------------------------------------------------------------------
module tensor_message_wire_parser_core_tb;
  import tmwp_pkg::*;

  typedef enum logic [2:0] {AT_KEY, AT_VALUE, AT_LENGTH, AT_PAYLOAD, AT_DRAIN} parse_step_t;

  class wire_item_tracker;
    parse_step_t step;
    logic [63:0] acc;
    logic [3:0]  acc_bytes;
    logic [2:0]  field;
    logic [63:0] payload_left;
    logic [63:0] entry_left;
    bit          in_entry;
    out_beat_t   pending_items[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      step = AT_KEY;
      acc = '0;
      acc_bytes = '0;
      field = '0;
      payload_left = '0;
      entry_left = '0;
      in_entry = 1'b0;
    endfunction

    function int pending();
      return pending_items.size();
    endfunction

    function void note_result(input out_beat_t r);
      pending_items.insert(pending_items.size(), r);
    endfunction

    function logic [2:0] decode_key(input logic [63:0] key);
      logic [60:0] fnum;
      logic [2:0]  wt;
      fnum = key[63:3];
      wt = key[2:0];
      if (in_entry) begin
        if (wt != WT_LEN) return ERR_WIRE_TYPE;
        if (fnum == FNUM_KEY) field = FC_ENTRY_KEY;
        else if (fnum == FNUM_VALUE) field = FC_ENTRY_VALUE;
        else return ERR_UNKNOWN_FIELD;
        step = AT_LENGTH;
        return ERR_NONE;
      end
      if (fnum == FNUM_DIMS || fnum == FNUM_DTYPE) begin
        if (wt != WT_VARINT) return ERR_WIRE_TYPE;
        field = (fnum == FNUM_DIMS) ? FC_DIMS : FC_DTYPE;
        step = AT_VALUE;
        return ERR_NONE;
      end
      if (fnum == FNUM_NAME) field = FC_NAME;
      else if (fnum == FNUM_RAW) field = FC_RAW;
      else if (fnum == FNUM_DOC) field = FC_DOC;
      else if (fnum == FNUM_ENTRY) field = FC_ENTRY;
      else return ERR_UNKNOWN_FIELD;
      if (wt != WT_LEN) return ERR_WIRE_TYPE;
      step = AT_LENGTH;
      return ERR_NONE;
    endfunction

    function void take_byte(input in_beat_t b);
      logic [2:0]  err;
      logic [63:0] v;
      out_beat_t   r;
      bit          have;
      int          sh;
      r = '0;
      r.item_kind = KIND_NONE;
      err = ERR_NONE;
      have = 1'b0;
      if (step == AT_DRAIN) begin
        if (!b.end_of_message) return;
        r.message_done = 1'b1;
        note_result(r);
        clear();
        return;
      end
      if (in_entry && entry_left != 0) entry_left--;
      if (step == AT_PAYLOAD) begin
        if (payload_left != 0) payload_left--;
        have = 1'b1;
        r.item_kind = KIND_PAYLOAD;
        r.field_code = field;
        r.item_value = {56'd0, b.in_byte};
        if (payload_left == 0) begin
          r.payload_last = 1'b1;
          step = AT_KEY;
        end
      end else begin
        sh = 7 * int'(acc_bytes);
        if (sh < 64) acc |= {57'd0, b.in_byte[6:0]} << sh;
        acc_bytes = acc_bytes + 4'd1;
        if (b.in_byte[7]) begin
          if (acc_bytes >= MAX_VARINT_BYTES) err = ERR_VARINT_LONG;
        end else begin
          v = acc;
          acc = '0;
          acc_bytes = '0;
          case (step)
            AT_KEY: err = decode_key(v);
            AT_VALUE: begin
              have = 1'b1;
              r.item_kind = KIND_VARINT;
              r.field_code = field;
              r.item_value = v;
              step = AT_KEY;
            end
            default: begin
              if (in_entry && v > entry_left) begin
                err = ERR_TRUNCATED;
              end else begin
                have = 1'b1;
                r.item_kind = KIND_LENGTH;
                r.field_code = field;
                r.item_value = v;
                if (field == FC_ENTRY) begin
                  if (v != 0) begin
                    in_entry = 1'b1;
                    entry_left = v;
                  end
                  step = AT_KEY;
                end else begin
                  payload_left = v;
                  step = (v != 0) ? AT_PAYLOAD : AT_KEY;
                end
              end
            end
          endcase
        end
      end
      if (err == ERR_NONE && in_entry && entry_left == 0) begin
        if (step == AT_KEY && acc_bytes == 0) in_entry = 1'b0;
        else err = ERR_TRUNCATED;
      end
      if (err == ERR_NONE && b.end_of_message &&
          (step != AT_KEY || acc_bytes != 0 || in_entry))
        err = ERR_TRUNCATED;
      if (err != ERR_NONE) begin
        r = '0;
        r.item_kind = KIND_NONE;
        r.message_done = b.end_of_message;
        r.error_code = err;
        note_result(r);
        if (b.end_of_message) begin
          clear();
        end else begin
          step = AT_DRAIN;
          acc = '0;
          acc_bytes = '0;
        end
        return;
      end
      if (b.end_of_message) begin
        r.message_done = 1'b1;
        note_result(r);
        clear();
        return;
      end
      if (have) note_result(r);
    endfunction

    function void compare_field(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_item(input out_beat_t got);
      out_beat_t want;
      if (pending_items.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = pending_items.pop_front();
      compare_field("field_code", 64'(want.field_code), 64'(got.field_code));
      compare_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
      compare_field("item_value", want.item_value, got.item_value);
      compare_field("payload_last", 64'(want.payload_last), 64'(got.payload_last));
      compare_field("message_done", 64'(want.message_done), 64'(got.message_done));
      compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_beat_t  byte_beat;
  logic      result_valid;
  logic      result_stall;
  out_beat_t result_beat;

  wire_item_tracker tracker;
  logic [7:0]       msg_q[$];
  bit               gaps_on;
  int               sent_bytes;

  tensor_message_wire_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) tracker.take_byte(byte_beat);
      if (result_valid && !result_stall) tracker.check_item(result_beat);
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int hold;
    hold = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (gaps_on && $urandom_range(0, 5) == 0) hold = int'($urandom_range(1, 7));
      result_stall <= (hold > 0);
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic int pad_count();
    return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 3)) : 0;
  endfunction

  function automatic logic [63:0] random_number();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 127));
      1: return 64'($urandom_range(128, 20000));
      2: return {$urandom, $urandom};
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic int pick_wt(input int good);
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 7)) : good;
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 40))
                                       : int'($urandom_range(0, 6));
  endfunction

  // padded encodings keep the value but add redundant continuation groups
  task automatic put_varint(input logic [63:0] v, input int pad);
    int n;
    int i;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    n = n + pad;
    if (n > 10) n = 10;
    for (i = 0; i < n; i++) add_byte({i < n - 1, 7'(v >> (7 * i))});
  endtask

  task automatic put_key(input int fnum, input int wt);
    put_varint((64'(fnum) << 3) | 64'(wt), pad_count());
  endtask

  task automatic put_number(input int fnum);
    put_key(fnum, pick_wt(int'(WT_VARINT)));
    put_varint(random_number(), pad_count());
  endtask

  task automatic put_string(input int fnum, input int len);
    put_key(fnum, pick_wt(int'(WT_LEN)));
    put_varint(64'(len), pad_count());
    repeat (len) add_byte(8'($urandom));
  endtask

  task automatic put_entry();
    logic [7:0] inner[$];
    int         s;
    int         len;
    s = msg_q.size();
    repeat ($urandom_range(0, 2))
      put_string(($urandom_range(0, 5) == 0) ? int'($urandom_range(3, 20))
                                             : int'($urandom_range(1, 2)),
                 int'($urandom_range(0, 4)));
    while (msg_q.size() > s) inner.push_front(msg_q.pop_back());
    len = inner.size();
    if ($urandom_range(0, 5) == 0) len = (len == 0 || $urandom_range(0, 1)) ? len + 1 : len - 1;
    put_key(16, pick_wt(int'(WT_LEN)));
    put_varint(64'(len), pad_count());
    foreach (inner[i]) add_byte(inner[i]);
  endtask

  task automatic build_message();
    int at;
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0: put_number(1);
        1: put_number(2);
        2: put_string(8, pick_len());
        3: put_string(9, pick_len());
        4: put_string(12, pick_len());
        default: put_entry();
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: begin
          at = int'($urandom_range(1, msg_q.size()));
          while (msg_q.size() > at) void'(msg_q.pop_back());
        end
        1: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
        2: msg_q.insert($urandom_range(0, msg_q.size()), 8'($urandom));
        3: begin
          repeat ($urandom_range(9, 11)) add_byte(8'h80 | 8'($urandom));
          add_byte(8'($urandom_range(0, 127)));
        end
        default: begin
          // key that would alias a known field if its upper bits were lost
          put_varint(((64'd8 + (64'd1 << $urandom_range(5, 60))) << 3) | 64'(WT_LEN), 0);
          put_varint(64'd1, 0);
          add_byte(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 7));
      @(negedge clk);
      byte_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_beat <= '{in_byte: data, end_of_message: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_beat = '0;
    gaps_on = 1'b1;
    sent_bytes = 0;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // dims at full width, with bits above bit 63 dropped
    msg_q = '{8'h08};
    repeat (9) add_byte(8'hFF);
    add_byte(8'h7F);
    send_message();
    msg_q = '{8'h10, 8'h00};
    send_message();
    // raw with one byte, then an empty name
    msg_q = '{8'h4A, 8'h01, 8'hFF, 8'h42, 8'h00};
    send_message();
    // entry holding a key string and an empty value string
    msg_q = '{8'h82, 8'h01, 8'h05, 8'h0A, 8'h01, 8'h41, 8'h12, 8'h00};
    send_message();
    // empty entry
    msg_q = '{8'h82, 8'h01, 8'h00};
    send_message();
    // entry string longer than the entry, then dropped bytes
    msg_q = '{8'h82, 8'h01, 8'h02, 8'h0A, 8'h05, 8'h00};
    send_message();
    // unknown field
    msg_q = '{8'h18, 8'h55};
    send_message();
    // wrong wire type on the end byte
    msg_q = '{8'h09};
    send_message();
    // key varint too long
    msg_q.delete();
    repeat (10) add_byte(8'h80);
    add_byte(8'h00);
    send_message();
    // payload cut short by the end of message
    msg_q = '{8'h62, 8'h02, 8'h11};
    send_message();

    while (sent_bytes < 580) begin
      gaps_on = (sent_bytes < 230) || (sent_bytes >= 300 && sent_bytes < 480);
      build_message();
      send_message();
    end
    gaps_on = 1'b0;
    @(negedge clk);
    byte_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tensor_message_wire_parser_core_tb: clean");
    end else begin
      $display("tensor_message_wire_parser_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tensor_message_wire_parser_core_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tmwp_pkg.sv
rtl/tmwp_decode.sv
rtl/tensor_message_wire_parser_core.sv
tb/tensor_message_wire_parser_core_tb.sv
